/* rtl/resonator_filter_bank_core_macros.svh */
// Assertion macros shared by the resonator filter bank RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef RESONATOR_FILTER_BANK_CORE_MACROS_SVH
`define RESONATOR_FILTER_BANK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define RFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define RFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/rfb_pkg.sv */
// Shared constants, types and helper functions of the resonator filter bank.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package rfb_pkg;

	localparam int MAX_BANDS = 32;
	localparam int BAND_W    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int CNT_W     = $clog2(MAX_BANDS + 1);
	localparam int BCW       = (CNT_W > 6) ? CNT_W : 6;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 24;
	localparam int LEVEL_W  = 16;
	localparam int ACC_W    = 44;
	localparam int PROD_W   = 57;

	localparam int QUO_W  = 15;
	localparam int QCNT_W = $clog2(QUO_W);
	localparam int DIV_W  = 52;

	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic [24:0] REGEN_K = 25'd8389;

	typedef enum logic [1:0] {
		CFG_MIX   = 2'd0,
		CFG_DRIVE = 2'd1,
		CFG_REGEN = 2'd2,
		CFG_BANDS = 2'd3
	} rfb_cfg_idx_t;

	typedef enum logic [2:0] {
		CS_B0     = 3'd0,
		CS_B1     = 3'd1,
		CS_B2     = 3'd2,
		CS_A1     = 3'd3,
		CS_A2     = 3'd4,
		CS_WEIGHT = 3'd5
	} rfb_coef_sel_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} rfb_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rfb_div_stat_t;

	// tanh(k/8) in Q0.15 for k = 0..32; larger codes hold at tanh(4).
	function automatic logic [14:0] tanh_tab(input logic [5:0] k);
		logic [14:0] t;
		case (k)
			6'd0:  t = 15'd0;
			6'd1:  t = 15'd4075;
			6'd2:  t = 15'd8025;
			6'd3:  t = 15'd11743;
			6'd4:  t = 15'd15143;
			6'd5:  t = 15'd18173;
			6'd6:  t = 15'd20813;
			6'd7:  t = 15'd23066;
			6'd8:  t = 15'd24956;
			6'd9:  t = 15'd26519;
			6'd10: t = 15'd27797;
			6'd11: t = 15'd28830;
			6'd12: t = 15'd29660;
			6'd13: t = 15'd30322;
			6'd14: t = 15'd30847;
			6'd15: t = 15'd31262;
			6'd16: t = 15'd31589;
			6'd17: t = 15'd31846;
			6'd18: t = 15'd32048;
			6'd19: t = 15'd32206;
			6'd20: t = 15'd32329;
			6'd21: t = 15'd32426;
			6'd22: t = 15'd32501;
			6'd23: t = 15'd32560;
			6'd24: t = 15'd32606;
			6'd25: t = 15'd32642;
			6'd26: t = 15'd32670;
			6'd27: t = 15'd32691;
			6'd28: t = 15'd32708;
			6'd29: t = 15'd32721;
			6'd30: t = 15'd32732;
			6'd31: t = 15'd32740;
			default: t = 15'd32746;
		endcase
		return t;
	endfunction

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Clamp a Q0.15 level to at most one.
	function automatic logic [16:0] lim_q15(input logic [LEVEL_W-1:0] v);
		logic [16:0] r;
		if (17'(v) > ONE_Q15)
			r = ONE_Q15;
		else
			r = 17'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/rfb_if.sv */
// Handshake channels of the resonator filter bank: input items, results and
// configuration writes. Depends on rfb_pkg for field widths.
`default_nettype none

interface rfb_in_if import rfb_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [4:0]                 band_index;
	logic [2:0]                 coef_select;
	logic signed [COEF_W-1:0]   coef_value;

	modport source (output valid, mode, sample_in, band_index, coef_select, coef_value,
		input ready);
	modport sink (input valid, mode, sample_in, band_index, coef_select, coef_value,
		output ready);
endinterface

interface rfb_out_if import rfb_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

interface rfb_cfg_if import rfb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         index;
	logic [LEVEL_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/rfb_div.sv */
// Restoring unsigned divider, one quotient bit per cycle, for the filter bank.
// Depends on rfb_pkg; the caller guarantees num < den * 2^QUO_W.
`default_nettype none

module rfb_div import rfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfb_div_ctl_t          ctl,
	output rfb_div_stat_t         stat,
	output logic [QUO_W-1:0]      quo
);

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  quo_q;
	logic              fit;

	assign fit = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - QCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= ctl.num;
			dsr_q <= ctl.den << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fit)
				rem_q <= rem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire

/* rtl/resonator_filter_bank_core.sv */
// Resonator filter bank, top level: bands of biquad resonators walked one band at a
// time on a single shared multiplier, plus a shared bit-serial divider.
// Depends on rfb_pkg, rfb_if, rfb_div and resonator_filter_bank_core_macros.svh.
//
// An audio item (mode 0) runs through the active bands in turn, each band being
// a transposed direct form II biquad fed by a running feed signal which every
// band nudges by a tanh regeneration term. The weighted band outputs are summed,
// soft-clipped, mixed with the dry sample and clamped to Q1.15; one result is
// produced per audio item. A coefficient item (mode 1) writes one coefficient or
// weight of one band in the cycle it is accepted and produces no result. The
// block takes one item at a time: each active band costs nine passes through
// the 32x25 multiplier, each product registered before use, and a 15-step
// division by the band count, and the output stage adds one multiply for the
// clip gain, a second 15-step division for the soft clip and two multiplies
// for the dry/wet mix. The band count is 12 after reset.
// A finished result waits in the output register; the next item is accepted
// while it waits, and the sequencer only stalls if a second result is ready
// before the first has been taken. Configuration writes are always taken and
// must only be made while the block is idle.
`default_nettype none
`include "resonator_filter_bank_core_macros.svh"

module resonator_filter_bank_core import rfb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rfb_cfg_if.sink  cfg,
	rfb_in_if.sink   item,
	rfb_out_if.source result
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_B0, ST_B1, ST_A1, ST_B2, ST_A2, ST_WY, ST_TH, ST_RG,
		ST_RM, ST_RK, ST_DVS, ST_DIVB, ST_FIN, ST_FV, ST_DIVF, ST_MX,
		ST_MD, ST_OUT, ST_SEND
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LEVEL_W-1:0] mix_q, drive_q, regen_q;
	logic [5:0]         bands_q;

	// Coefficient and delay stores, one entry per band.
	logic signed [COEF_W-1:0] b0_q [MAX_BANDS];
	logic signed [COEF_W-1:0] b1_q [MAX_BANDS];
	logic signed [COEF_W-1:0] b2_q [MAX_BANDS];
	logic signed [COEF_W-1:0] a1_q [MAX_BANDS];
	logic signed [COEF_W-1:0] a2_q [MAX_BANDS];
	logic signed [COEF_W-1:0] w_q  [MAX_BANDS];
	logic signed [31:0]       d1_q [MAX_BANDS];
	logic signed [31:0]       d2_q [MAX_BANDS];

	logic [BAND_W-1:0]          bi_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	// Datapath registers.
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [31:0]         feed_q;
	logic signed [31:0]         y_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [PROD_W-1:0]   t1_q;
	logic [14:0]                mag_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       neg_q;
	logic signed [SAMPLE_W-1:0] res_q;

	// Shared divider.
	rfb_div_ctl_t     div_ctl;
	rfb_div_stat_t    div_stat;
	logic [QUO_W-1:0] div_quo;

	rfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// Handshakes.
	logic in_xfer, cfg_xfer, out_xfer;
	assign item.ready    = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_xfer       = item.valid && item.ready;
	assign cfg_xfer      = cfg.valid && cfg.ready;
	assign out_xfer      = result.valid && result.ready;
	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

	// Effective levels and band count.
	logic [16:0]    mix_lim, drive_lim, regen_lim;
	logic [19:0]    gain;
	logic [BCW-1:0] bc_raw, bc;
	logic           last_band;

	assign mix_lim   = lim_q15(mix_q);
	assign drive_lim = lim_q15(drive_q);
	assign regen_lim = lim_q15(regen_q);
	// Clip gain is one plus nine times drive, in Q5.15.
	assign gain = 20'(ONE_Q15) + {drive_lim, 3'b000} + 20'(drive_lim);

	always_comb begin
		bc_raw = BCW'(bands_q);
		if (bc_raw == '0)
			bc = BCW'(1);
		else if (bc_raw > BCW'(MAX_BANDS))
			bc = BCW'(MAX_BANDS);
		else
			bc = bc_raw;
	end

	assign last_band = ((BCW'(bi_q) + BCW'(1)) == bc);

	// Coefficient write addressing; writes beyond the store are dropped.
	logic              band_ok;
	logic [BAND_W-1:0] wr_idx;
	assign band_ok = (32'(item.band_index) < 32'(MAX_BANDS));
	assign wr_idx  = BAND_W'(item.band_index);

	// Current band reads.
	logic signed [31:0] d1_rd, d2_rd;
	assign d1_rd = d1_q[bi_q];
	assign d2_rd = d2_q[bi_q];

	// Band arithmetic around the registered product.
	logic signed [31:0]  y_n, z1_n, z2_n, feed_n;
	logic signed [57:0]  pdiff;
	logic signed [PROD_W-1:0] p_sh20;
	logic [31:0]         u_y;
	logic                th_big;
	logic [4:0]          th_idx;
	logic [16:0]         th_fr;
	logic [14:0]         th_lo, th_hi, th_diff;
	logic signed [33:0]  feed_sum;

	assign p_sh20 = prod_q >>> 20;
	assign pdiff  = 58'(t1_q) - 58'(prod_q);
	assign y_n    = sat32(64'(p_sh20) + 64'(d1_rd));
	assign z1_n   = sat32(64'(pdiff >>> 20) + 64'(d2_rd));
	assign z2_n   = sat32(64'(pdiff >>> 20));

	// tanh lookup on |y| with 17 fraction bits of interpolation.
	assign u_y     = y_q[31] ? (32'd0 - 32'(y_q)) : 32'(y_q);
	assign th_big  = |u_y[31:22];
	assign th_idx  = u_y[21:17];
	assign th_fr   = u_y[16:0];
	assign th_lo   = tanh_tab({1'b0, th_idx});
	assign th_hi   = tanh_tab({1'b0, th_idx} + 6'd1);
	assign th_diff = th_hi - th_lo;

	// The regeneration step carries the sign of y.
	assign feed_sum = y_q[31] ? (34'(feed_q) - 34'({1'b0, div_quo}))
	                          : (34'(feed_q) + 34'({1'b0, div_quo}));
	assign feed_n   = sat32(64'(feed_sum));

	// Output stage arithmetic.
	logic signed [31:0]       wet_sum;
	logic signed [PROD_W-1:0] v_sh;
	logic [36:0]              absv_n;
	logic signed [SAMPLE_W-1:0] wet;
	logic signed [57:0]       o_full;
	logic signed [42:0]       o_sh;
	logic signed [SAMPLE_W-1:0] o_clamp;

	assign wet_sum = sat32(64'(acc_q));
	assign v_sh    = prod_q >>> 15;
	assign absv_n  = prod_q[PROD_W-1] ? 37'(-v_sh) : 37'(v_sh);
	assign wet     = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign o_full  = 58'(t1_q) + 58'(prod_q);
	assign o_sh    = 43'(o_full >>> 15);

	always_comb begin
		if (o_sh > 43'sd32767)
			o_clamp = 16'sh7FFF;
		else if (o_sh < -43'sd32768)
			o_clamp = 16'sh8000;
		else
			o_clamp = o_sh[15:0];
	end

	// Shared multiplier operand selection; the product is registered.
	logic signed [31:0]       mul_a;
	logic signed [24:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_B0: begin
				mul_a = feed_q;
				mul_b = 25'(b0_q[bi_q]);
			end
			ST_B1: begin
				mul_a = feed_q;
				mul_b = 25'(b1_q[bi_q]);
			end
			ST_A1: begin
				mul_a = y_q;
				mul_b = 25'(a1_q[bi_q]);
			end
			ST_B2: begin
				mul_a = feed_q;
				mul_b = 25'(b2_q[bi_q]);
			end
			ST_A2: begin
				mul_a = y_q;
				mul_b = 25'(a2_q[bi_q]);
			end
			ST_WY: begin
				mul_a = y_q;
				mul_b = 25'(w_q[bi_q]);
			end
			ST_TH: begin
				mul_a = $signed({15'd0, th_fr});
				mul_b = $signed({10'd0, th_diff});
			end
			ST_RM: begin
				mul_a = $signed({17'd0, mag_q});
				mul_b = $signed({8'd0, regen_lim});
			end
			ST_RK: begin
				// regen * |t| stays below 2^30, so the low word is its value.
				mul_a = $signed({1'b0, prod_q[30:0]});
				mul_b = $signed(REGEN_K);
			end
			ST_FIN: begin
				mul_a = wet_sum;
				mul_b = $signed({5'd0, gain});
			end
			ST_MX: begin
				mul_a = 32'(wet);
				mul_b = $signed({8'd0, mix_lim});
			end
			ST_MD: begin
				mul_a = 32'(x_q);
				mul_b = $signed({8'd0, ONE_Q15 - mix_lim});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Divider requests: regeneration divides by band_count * 2^30, the soft
	// clip divides |v| * 2^15 by 2^20 + |v|.
	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.num   = '0;
		div_ctl.den   = '0;
		if (state_q == ST_DVS) begin
			div_ctl.start = 1'b1;
			div_ctl.num   = DIV_W'(prod_q[45:0]);
			div_ctl.den   = DIV_W'(bc) << 30;
		end else if (state_q == ST_FV) begin
			div_ctl.start = 1'b1;
			div_ctl.num   = DIV_W'({absv_n, 15'd0});
			div_ctl.den   = DIV_W'(absv_n) + (DIV_W'(1) << 20);
		end
	end

	// Sequencer, configuration and stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bi_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			mix_q       <= 16'd16384;
			drive_q     <= 16'd6554;
			regen_q     <= 16'd3277;
			bands_q     <= 6'd12;
			for (int i = 0; i < MAX_BANDS; i++) begin
				b0_q[i] <= '0;
				b1_q[i] <= '0;
				b2_q[i] <= '0;
				a1_q[i] <= '0;
				a2_q[i] <= '0;
				w_q[i]  <= '0;
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (cfg_xfer) begin
				case (cfg.index)
					CFG_MIX:   mix_q   <= cfg.data;
					CFG_DRIVE: drive_q <= cfg.data;
					CFG_REGEN: regen_q <= cfg.data;
					CFG_BANDS: bands_q <= cfg.data[5:0];
					default: ;
				endcase
			end

			// A transfer frees the output register unless a new sample is loaded now.
			if (out_xfer && (state_q != ST_SEND))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (item.mode) begin
							if (band_ok) begin
								case (item.coef_select)
									CS_B0:     b0_q[wr_idx] <= item.coef_value;
									CS_B1:     b1_q[wr_idx] <= item.coef_value;
									CS_B2:     b2_q[wr_idx] <= item.coef_value;
									CS_A1:     a1_q[wr_idx] <= item.coef_value;
									CS_A2:     a2_q[wr_idx] <= item.coef_value;
									CS_WEIGHT: w_q[wr_idx]  <= item.coef_value;
									default: ;
								endcase
							end
						end else begin
							bi_q    <= '0;
							state_q <= ST_B0;
						end
					end
				end
				ST_B0:  state_q <= ST_B1;
				ST_B1:  state_q <= ST_A1;
				ST_A1:  state_q <= ST_B2;
				ST_B2: begin
					d1_q[bi_q] <= z1_n;
					state_q    <= ST_A2;
				end
				ST_A2:  state_q <= ST_WY;
				ST_WY: begin
					d2_q[bi_q] <= z2_n;
					state_q    <= ST_TH;
				end
				ST_TH:  state_q <= ST_RG;
				ST_RG:  state_q <= ST_RM;
				ST_RM:  state_q <= ST_RK;
				ST_RK:  state_q <= ST_DVS;
				ST_DVS: state_q <= ST_DIVB;
				ST_DIVB: begin
					if (div_stat.done) begin
						if (last_band) begin
							state_q <= ST_FIN;
						end else begin
							bi_q    <= bi_q + BAND_W'(1);
							state_q <= ST_B0;
						end
					end
				end
				ST_FIN: state_q <= ST_FV;
				ST_FV:  state_q <= ST_DIVF;
				ST_DIVF: begin
					if (div_stat.done)
						state_q <= ST_MX;
				end
				ST_MX:  state_q <= ST_MD;
				ST_MD:  state_q <= ST_OUT;
				ST_OUT: state_q <= ST_SEND;
				ST_SEND: begin
					// Hold the finished sample until the output register is free.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					x_q    <= item.sample_in;
					feed_q <= {{11{item.sample_in[15]}}, item.sample_in, 5'd0};
					acc_q  <= '0;
				end
			end
			ST_B1:  y_q  <= y_n;
			ST_A1:  t1_q <= prod_q;
			ST_A2:  t1_q <= prod_q;
			ST_TH:  acc_q <= acc_q + ACC_W'(p_sh20);
			ST_RG:  mag_q <= th_big ? tanh_tab(6'd32) : (th_lo + prod_q[31:17]);
			ST_DIVB: begin
				if (div_stat.done)
					feed_q <= feed_n;
			end
			ST_FV:  neg_q <= prod_q[PROD_W-1];
			ST_MD:  t1_q <= prod_q;
			ST_OUT: res_q <= o_clamp;
			default: ;
		endcase
	end

	`RFB_ASSERT_IMP(a_div_done_in_wait, clk, arst_n, div_stat.done,
		(state_q == ST_DIVB) || (state_q == ST_DIVF), "divider finished outside a wait state")
	`RFB_ASSERT_NXT(a_audio_busy, clk, arst_n, in_xfer && !item.mode,
		!item.ready, "block ready right after taking an audio item")
	`RFB_ASSERT_NXT(a_coef_no_result, clk, arst_n, in_xfer && item.mode,
		(state_q == ST_IDLE) && !$rose(out_valid_q), "coefficient write started processing")
	`RFB_ASSERT_IMP(a_band_in_range, clk, arst_n, state_q != ST_IDLE,
		BCW'(bi_q) < bc, "band counter beyond the active band count")
	`RFB_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_ctl.start,
		!div_stat.busy, "divider restarted while busy")

endmodule

`default_nettype wire
